FILE: sv/kic_pkg.sv
// shared types, constants and the byte-wide crc step for the key image checker
package kic_pkg;

	localparam int MAX_RECORDS_DEF  = 16;
	localparam int RECORD_BYTES_DEF = 64;
	localparam int IMAGE_LIMIT_DEF  = 4096;

	localparam logic [31:0] IMG_MAGIC   = 32'h4B45_5953;
	localparam logic [15:0] IMG_VERSION = 16'h0001;
	localparam logic [31:0] CRC_POLY    = 32'hEDB8_8320;
	localparam logic [31:0] CRC_INIT    = 32'hFFFF_FFFF;
	localparam int          MIN_LEN     = 11;

	// widest expected length: 11 + 255 * 255 fits in 17 bits
	localparam int EXP_W = 17;

	typedef enum logic [2:0] {
		V_OK        = 3'd0,
		V_SHORT     = 3'd1,
		V_MAGIC     = 3'd2,
		V_VERSION   = 3'd3,
		V_COUNT     = 3'd4,
		V_TRUNCATED = 3'd5,
		V_CRC       = 3'd6
	} verdict_t;

	typedef struct packed {
		logic [31:0] word;
		logic [15:0] version;
		logic [7:0]  count;
		logic [31:0] stored;
		logic [31:0] frozen;
	} hdr_t;

	// reflected crc-32, one byte, lsb first
	function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {24'd0, b};
		for (int k = 0; k < 8; k++) begin
			c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
		end
		return c;
	endfunction

endpackage

FILE: sv/kic_verdict.sv
// decision logic: orders the image checks and forms the verdict and count
module kic_verdict #(
	parameter int MAX_RECORDS = kic_pkg::MAX_RECORDS_DEF,
	parameter int IMAGE_LIMIT = kic_pkg::IMAGE_LIMIT_DEF,
	localparam int POS_W = $clog2(IMAGE_LIMIT + 2)
) (
	input  logic [POS_W-1:0]          len,
	input  logic [kic_pkg::EXP_W-1:0] exp_len,
	input  kic_pkg::hdr_t             hdr,
	output kic_pkg::verdict_t         verdict,
	output logic [7:0]                record_count
);

	logic [kic_pkg::EXP_W-1:0] len_x;
	logic                      len_bad;

	assign len_x   = kic_pkg::EXP_W'(len);
	assign len_bad = (exp_len > kic_pkg::EXP_W'(IMAGE_LIMIT))
		|| (len > POS_W'(IMAGE_LIMIT)) || (len_x < exp_len);

	always_comb begin
		priority if (len < POS_W'(kic_pkg::MIN_LEN)) begin
			verdict = kic_pkg::V_SHORT;
		end else if (hdr.word != kic_pkg::IMG_MAGIC) begin
			verdict = kic_pkg::V_MAGIC;
		end else if (hdr.version != kic_pkg::IMG_VERSION) begin
			verdict = kic_pkg::V_VERSION;
		end else if (hdr.count == 8'd0 || hdr.count > 8'(MAX_RECORDS)) begin
			verdict = kic_pkg::V_COUNT;
		end else if (len_bad) begin
			verdict = kic_pkg::V_TRUNCATED;
		end else if (hdr.frozen != hdr.stored) begin
			verdict = kic_pkg::V_CRC;
		end else begin
			verdict = kic_pkg::V_OK;
		end
	end

	assign record_count = (verdict == kic_pkg::V_OK) ? hdr.count : 8'd0;

endmodule

FILE: sv/key_image_checker_top.sv
// Key image checker: takes a stored key-store image one byte per item (tlast on the final
// byte) and returns one verdict item per image with the header record count. Sustained rate
// is one byte per cycle with no gaps between images; a byte goes through an input register,
// where the byte-wide crc step, header capture and length tracking are computed from it,
// and the verdict of the final byte lands in the output register. The output register
// frees the input side while a verdict waits; input stalls only once a second verdict is
// ready behind an untaken one. Bytes past the expected image length are ignored; after
// each verdict the state returns to its reset values for the next image.
module key_image_checker_top #(
	parameter int MAX_RECORDS  = kic_pkg::MAX_RECORDS_DEF,
	parameter int RECORD_BYTES = kic_pkg::RECORD_BYTES_DEF,
	parameter int IMAGE_LIMIT  = kic_pkg::IMAGE_LIMIT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic        s_tlast,   // last_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata    // [2:0] verdict, [10:3] record_count, rest zero
);

	localparam int POS_W = $clog2(IMAGE_LIMIT + 2);
	localparam int EXP_W = kic_pkg::EXP_W;

	// input register
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;

	logic advance;
	logic out_free;

	// image state
	logic [POS_W-1:0] pos_q;
	logic [31:0]      crc_q;
	logic [EXP_W-1:0] exp_q;
	kic_pkg::hdr_t    hdr_q;

	logic [POS_W-1:0] pos_n;
	logic [31:0]      crc_n;
	logic [EXP_W-1:0] exp_n;
	kic_pkg::hdr_t    hdr_n;
	logic [EXP_W-1:0] pos_x;

	kic_pkg::verdict_t verdict;
	logic [7:0]        record_count;

	assign out_free = !m_tvalid || m_tready;
	assign advance  = valid_s1 && (!last_s1 || out_free);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	assign pos_x = EXP_W'(pos_q);

	always_comb begin
		hdr_n = hdr_q;
		crc_n = crc_q;
		exp_n = exp_q;
		if (pos_q < POS_W'(4)) begin
			hdr_n.word = {hdr_q.word[23:0], byte_s1};
		end else if (pos_q < POS_W'(6)) begin
			hdr_n.version = {hdr_q.version[7:0], byte_s1};
		end else if (pos_q == POS_W'(6)) begin
			hdr_n.count = byte_s1;
			exp_n = EXP_W'(kic_pkg::MIN_LEN)
				+ {{(EXP_W-8){1'b0}}, byte_s1} * EXP_W'(RECORD_BYTES);
		end
		// bytes before the last four feed the crc, the last four are the stored crc
		if (pos_q <= POS_W'(IMAGE_LIMIT)) begin
			if (pos_x + EXP_W'(4) < exp_q) begin
				crc_n = kic_pkg::crc_byte(crc_q, byte_s1);
			end else if (pos_x < exp_q) begin
				if (pos_x + EXP_W'(4) == exp_q) begin
					hdr_n.frozen = ~crc_q;
				end
				hdr_n.stored = {hdr_q.stored[23:0], byte_s1};
			end
		end
		pos_n = (pos_q < POS_W'(IMAGE_LIMIT + 1)) ? pos_q + POS_W'(1) : pos_q;
	end

	kic_verdict #(
		.MAX_RECORDS(MAX_RECORDS),
		.IMAGE_LIMIT(IMAGE_LIMIT)
	) u_verdict (
		.len         (pos_n),
		.exp_len     (exp_n),
		.hdr         (hdr_n),
		.verdict     (verdict),
		.record_count(record_count)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			crc_q <= kic_pkg::CRC_INIT;
			exp_q <= EXP_W'(kic_pkg::MIN_LEN);
			hdr_q <= '0;
		end else if (advance) begin
			if (last_s1) begin
				pos_q <= '0;
				crc_q <= kic_pkg::CRC_INIT;
				exp_q <= EXP_W'(kic_pkg::MIN_LEN);
				hdr_q <= '0;
			end else begin
				pos_q <= pos_n;
				crc_q <= crc_n;
				exp_q <= exp_n;
				hdr_q <= hdr_n;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (out_free) begin
			m_tvalid <= advance && last_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && advance && last_s1) begin
			m_tdata <= {5'd0, record_count, verdict};
		end
	end

	// a passing image always carries a nonzero count, a failing one carries zero
	a_ok_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[2:0] == kic_pkg::V_OK |-> m_tdata[10:3] != 8'd0)
		else $error("ok verdict with zero record count");

	a_fail_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[2:0] != kic_pkg::V_OK |-> m_tdata[10:3] == 8'd0)
		else $error("failed verdict with nonzero record count");

	a_verdict_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[2:0] != 3'd7 && m_tdata[15:11] == 5'd0)
		else $error("verdict code out of range");

	// position saturates and restarts after each final byte
	a_pos_sat: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= POS_W'(IMAGE_LIMIT + 1))
		else $error("byte position past saturation");

	a_pos_restart: assert property (@(posedge clk) disable iff (!arst_n)
		advance && last_s1 |=> pos_q == '0 && crc_q == kic_pkg::CRC_INIT)
		else $error("state not cleared after final byte");

endmodule
